// File: rtl/core/nmea_sentence_checker_core_assert.svh
// Assertion macros for the NMEA sentence checker.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef NMEA_SENTENCE_CHECKER_CORE_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define NSC_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("nmea checker: same-cycle rule violated");

// Next-cycle implication, checked while out of reset.
`define NSC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("nmea checker: next-cycle rule violated");

`endif

// File: rtl/core/nmea_sc_pkg.sv
// Shared types, codes and helpers for the NMEA sentence checker.
// No dependencies.
package nmea_sc_pkg;

  // line phase codes
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX2 = 3'd3;
  localparam logic [2:0] PH_TAIL = 3'd4;

  // characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // talker-stripped sentence tags
  localparam logic [23:0] TAG_RMC = 24'h524D43;
  localparam logic [23:0] TAG_VTG = 24'h565447;
  localparam logic [23:0] TAG_GGA = 24'h474741;

  localparam logic [5:0] COMMA_MAX = 6'd62;

  // line status codes
  localparam logic [1:0] ST_NO_DOLLAR = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_MISMATCH  = 2'd2;
  localparam logic [1:0] ST_VALID     = 2'd3;

  // sentence kind codes
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_RMC   = 2'd1;
  localparam logic [1:0] KIND_VTG   = 2'd2;
  localparam logic [1:0] KIND_GGA   = 2'd3;

  localparam logic [15:0] BAD_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  xor_acc;
    logic [7:0]  hex_value;
    logic        hex_bad;
    logic [23:0] tag_tail;
    logic        comma_seen;
    logic [5:0]  comma_total;
  } line_st_t;

  typedef struct packed {
    logic [1:0]  line_status;
    logic [1:0]  sentence_kind;
    logic [5:0]  field_total;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic [15:0] bad_line_total;
  } result_t;

  localparam line_st_t LINE_CLEAR = '{
    phase: PH_HUNT, xor_acc: 8'h00, hex_value: 8'h00, hex_bad: 1'b0,
    tag_tail: 24'h000000, comma_seen: 1'b0, comma_total: 6'd0
  };

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) d = {1'b0, 4'(c - 8'h41 + 8'd10)};
    else if (c >= 8'h61 && c <= 8'h66) d = {1'b0, 4'(c - 8'h61 + 8'd10)};
    return d;
  endfunction

endpackage

// File: rtl/core/nmea_sc_step.sv
// Per-byte update of the line state and result formation at line end.
// Depends on nmea_sc_pkg.
module nmea_sc_step (
  input  nmea_sc_pkg::line_st_t line_st,
  input  logic [15:0]           bad_lines,
  input  logic [7:0]            char_in,
  input  logic                  end_of_input,
  output nmea_sc_pkg::line_st_t line_nxt,
  output logic [15:0]           bad_nxt,
  output logic                  emit,
  output nmea_sc_pkg::result_t  result
);

  nmea_sc_pkg::line_st_t ab;
  logic [4:0]            dig;
  logic                  newline;
  logic [1:0]            status;
  logic [1:0]            kind;
  logic [15:0]           bad_cnt;

  assign newline = (char_in == nmea_sc_pkg::CH_NEWLINE);
  assign dig     = nmea_sc_pkg::hex_digit(char_in);
  assign emit    = newline || end_of_input;

  // absorb the byte (newline is not part of the line)
  always_comb begin
    ab = line_st;
    if (!newline) begin
      case (line_st.phase)
        nmea_sc_pkg::PH_HUNT: begin
          if (char_in == nmea_sc_pkg::CH_DOLLAR) begin
            ab.phase    = nmea_sc_pkg::PH_BODY;
            ab.tag_tail = {16'h0000, nmea_sc_pkg::CH_DOLLAR};
          end
        end
        nmea_sc_pkg::PH_BODY: begin
          if (char_in == nmea_sc_pkg::CH_STAR) begin
            ab.phase = nmea_sc_pkg::PH_HEX1;
          end else begin
            ab.xor_acc = line_st.xor_acc ^ char_in;
            if (char_in == nmea_sc_pkg::CH_COMMA) begin
              ab.comma_seen = 1'b1;
              if (line_st.comma_total < nmea_sc_pkg::COMMA_MAX)
                ab.comma_total = line_st.comma_total + 6'd1;
            end else if (!line_st.comma_seen) begin
              ab.tag_tail = {line_st.tag_tail[15:0], char_in};
            end
          end
        end
        nmea_sc_pkg::PH_HEX1: begin
          if (dig[4]) ab.hex_bad = 1'b1;
          else ab.hex_value = {dig[3:0], 4'h0};
          ab.phase = nmea_sc_pkg::PH_HEX2;
        end
        nmea_sc_pkg::PH_HEX2: begin
          if (dig[4]) ab.hex_bad = 1'b1;
          else ab.hex_value = line_st.hex_value | {4'h0, dig[3:0]};
          ab.phase = nmea_sc_pkg::PH_TAIL;
        end
        default: ;
      endcase
    end
  end

  // classify the line as it stands after this byte
  always_comb begin
    if (ab.phase == nmea_sc_pkg::PH_HUNT)
      status = nmea_sc_pkg::ST_NO_DOLLAR;
    else if (ab.phase != nmea_sc_pkg::PH_TAIL || ab.hex_bad)
      status = nmea_sc_pkg::ST_MALFORMED;
    else if (ab.xor_acc != ab.hex_value)
      status = nmea_sc_pkg::ST_MISMATCH;
    else
      status = nmea_sc_pkg::ST_VALID;

    if (ab.tag_tail == nmea_sc_pkg::TAG_RMC)      kind = nmea_sc_pkg::KIND_RMC;
    else if (ab.tag_tail == nmea_sc_pkg::TAG_VTG) kind = nmea_sc_pkg::KIND_VTG;
    else if (ab.tag_tail == nmea_sc_pkg::TAG_GGA) kind = nmea_sc_pkg::KIND_GGA;
    else                                          kind = nmea_sc_pkg::KIND_OTHER;

    bad_cnt = bad_lines;
    if (status != nmea_sc_pkg::ST_NO_DOLLAR && status != nmea_sc_pkg::ST_VALID &&
        bad_lines != nmea_sc_pkg::BAD_MAX)
      bad_cnt = bad_lines + 16'd1;
  end

  always_comb begin
    result.line_status    = status;
    result.bad_line_total = bad_cnt;
    if (status == nmea_sc_pkg::ST_NO_DOLLAR) begin
      result.sentence_kind = nmea_sc_pkg::KIND_OTHER;
      result.field_total   = 6'd1;
      result.computed_sum  = 8'h00;
      result.received_sum  = 8'h00;
    end else begin
      result.sentence_kind = kind;
      result.field_total   = ab.comma_total + 6'd1;
      result.computed_sum  = ab.xor_acc;
      result.received_sum  = (status == nmea_sc_pkg::ST_MALFORMED) ? 8'h00 : ab.hex_value;
    end
  end

  assign line_nxt = emit ? nmea_sc_pkg::LINE_CLEAR : ab;
  assign bad_nxt  = emit ? bad_cnt : bad_lines;

endmodule

// File: rtl/core/nmea_sentence_checker_core.sv
// NMEA 0183 sentence checker. Takes one text byte per request on the in_
// channel and gives one result request per line (a line ends at 0x0A, which is
// not part of it, or after a byte flagged with in_end_of_input). A new byte
// can be taken every cycle unless it stalls as told below; a closing byte
// passes the input register, the combinational byte update and the result
// register before its result shows on out_valid and can be taken.
// The result register holds a waiting result while further bytes are still
// taken; bytes stall only when a line ends and the result register is still
// full. bad_line_total counts, with saturation,
// lines that hold a '$' but are malformed or fail the checksum.
// Depends on nmea_sc_pkg and nmea_sc_step.
module nmea_sentence_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  // byte requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  // result requests
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_line_status,
  output logic [1:0]  out_sentence_kind,
  output logic [5:0]  out_field_total,
  output logic [7:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  output logic [15:0] out_bad_line_total
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eoi_r;

  // running line state and the persistent bad-line count
  nmea_sc_pkg::line_st_t line_r;
  nmea_sc_pkg::line_st_t line_nxt;
  logic [15:0]           bad_r;
  logic [15:0]           bad_nxt;

  // result register
  logic                  out_valid_r;
  nmea_sc_pkg::result_t  res_r;
  nmea_sc_pkg::result_t  res_nxt;

  logic emit;
  logic out_free;
  logic s1_adv;

  nmea_sc_step u_step (
    .line_st      (line_r),
    .bad_lines    (bad_r),
    .char_in      (s1_char_r),
    .end_of_input (s1_eoi_r),
    .line_nxt     (line_nxt),
    .bad_nxt      (bad_nxt),
    .emit         (emit),
    .result       (res_nxt)
  );

  // a byte that closes a line needs room in the result register
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_in;
      s1_eoi_r  <= in_end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= nmea_sc_pkg::LINE_CLEAR;
      bad_r  <= 16'h0000;
    end else if (s1_adv) begin
      line_r <= line_nxt;
      bad_r  <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_line_status    = res_r.line_status;
  assign out_sentence_kind  = res_r.sentence_kind;
  assign out_field_total    = res_r.field_total;
  assign out_computed_sum   = res_r.computed_sum;
  assign out_received_sum   = res_r.received_sum;
  assign out_bad_line_total = res_r.bad_line_total;

endmodule

// File: rtl/core/nmea_sc_checker.sv
// Port-level checks for the NMEA sentence checker, bound to the top level.
// Depends on nmea_sentence_checker_core_assert.svh and nmea_sentence_checker_core.
`include "nmea_sentence_checker_core_assert.svh"

module nmea_sc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_in,
  input logic        in_end_of_input,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_line_status,
  input logic [1:0]  out_sentence_kind,
  input logic [5:0]  out_field_total,
  input logic [7:0]  out_computed_sum,
  input logic [7:0]  out_received_sum,
  input logic [15:0] out_bad_line_total
);

  // a stalled byte request holds
  `NSC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_char_in) && $stable(in_end_of_input))

  // a stalled result holds
  `NSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bad_line_total) && $stable(out_computed_sum) && $stable(out_line_status))

  // a line without a dollar carries fixed fields
  `NSC_ASSERT_IMPL(a_no_dollar_fixed, out_valid && out_line_status == nmea_sc_pkg::ST_NO_DOLLAR, out_sentence_kind == nmea_sc_pkg::KIND_OTHER && out_field_total == 6'd1 && out_computed_sum == 8'h00 && out_received_sum == 8'h00)

  // a malformed tail reports no received checksum
  `NSC_ASSERT_IMPL(a_malformed_rsum, out_valid && out_line_status == nmea_sc_pkg::ST_MALFORMED, out_received_sum == 8'h00 && out_field_total != 6'd0)

  // valid means the sums agree, mismatch means they differ
  `NSC_ASSERT_IMPL(a_sum_agree, out_valid && (out_line_status == nmea_sc_pkg::ST_VALID || out_line_status == nmea_sc_pkg::ST_MISMATCH), (out_computed_sum == out_received_sum) == (out_line_status == nmea_sc_pkg::ST_VALID))

endmodule

bind nmea_sentence_checker_core nmea_sc_checker u_nmea_sc_checker (.*);

// File: tb/tb_nmea_sentence_checker_core.sv
// Testbench for nmea_sentence_checker_core: streams NMEA text requests, predicts
// each line's result in-bench and checks every result request field by field.
// Depends on nmea_sc_pkg and the checker RTL.
`timescale 1ns / 100ps

module tb_nmea_sentence_checker_core;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BYTES = 450;    // random text per idling phase

  // how a generated line is closed
  typedef enum {END_NL, END_FLAG, END_BOTH} line_end_e;

  // what follows the body of a generated sentence
  typedef enum {
    TAIL_GOOD, TAIL_WRONG, TAIL_NONE, TAIL_STAR_ONLY, TAIL_ONE_DIGIT, TAIL_BAD_DIGIT
  } tail_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_req_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_in = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_line_status;
  logic [1:0]  out_sentence_kind;
  logic [5:0]  out_field_total;
  logic [7:0]  out_computed_sum;
  logic [7:0]  out_received_sum;
  logic [15:0] out_bad_line_total;

  nmea_sentence_checker_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_in         (in_char_in),
    .in_end_of_input    (in_end_of_input),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_status    (out_line_status),
    .out_sentence_kind  (out_sentence_kind),
    .out_field_total    (out_field_total),
    .out_computed_sum   (out_computed_sum),
    .out_received_sum   (out_received_sum),
    .out_bad_line_total (out_bad_line_total)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  text_req_t             text_q[$];          // byte requests waiting for the driver
  nmea_sc_pkg::result_t  line_reports_q[$];  // predicted results, oldest first
  int         error_count = 0;
  int         cycle_count = 0;
  int         bytes_queued = 0;
  int         gap_pct = 0;        // sender idle chance, percent
  int         stall_pct = 0;      // receiver stall chance, percent
  bit         in_took = 1'b0;     // byte request accepted at the last rising edge

  // line builder scratch
  logic [7:0] line_buf[$];
  logic [7:0] body_xor;

  // predictor copy of the checker state
  nmea_sc_pkg::line_st_t line_st = nmea_sc_pkg::LINE_CLEAR;
  logic [15:0]           bad_line_count = 16'h0000;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // {not_hex, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
      return {1'b0, 4'(c[3:0] + 4'd9)};
    return 5'h10;
  endfunction

  // Advances the line state by one byte; done is set when the byte closes a line.
  task automatic predict_line_byte(input logic [7:0] c, input logic eol,
                                   output bit done, output nmea_sc_pkg::result_t r);
    logic [4:0] d;
    done = 1'b0;
    r = '0;
    if (c != nmea_sc_pkg::CH_NEWLINE) begin
      case (line_st.phase)
        nmea_sc_pkg::PH_HUNT: begin
          if (c == nmea_sc_pkg::CH_DOLLAR) begin
            line_st.phase = nmea_sc_pkg::PH_BODY;
            line_st.tag_tail = {16'h0000, nmea_sc_pkg::CH_DOLLAR};
          end
        end
        nmea_sc_pkg::PH_BODY: begin
          if (c == nmea_sc_pkg::CH_STAR) begin
            line_st.phase = nmea_sc_pkg::PH_HEX1;
          end else begin
            line_st.xor_acc = line_st.xor_acc ^ c;
            if (c == nmea_sc_pkg::CH_COMMA) begin
              line_st.comma_seen = 1'b1;
              if (line_st.comma_total < nmea_sc_pkg::COMMA_MAX) line_st.comma_total++;
            end else if (!line_st.comma_seen) begin
              line_st.tag_tail = {line_st.tag_tail[15:0], c};
            end
          end
        end
        nmea_sc_pkg::PH_HEX1: begin
          d = hex_nibble(c);
          if (d[4]) line_st.hex_bad = 1'b1;
          else line_st.hex_value = {d[3:0], 4'h0};
          line_st.phase = nmea_sc_pkg::PH_HEX2;
        end
        nmea_sc_pkg::PH_HEX2: begin
          d = hex_nibble(c);
          if (d[4]) line_st.hex_bad = 1'b1;
          else line_st.hex_value[3:0] = d[3:0];
          line_st.phase = nmea_sc_pkg::PH_TAIL;
        end
        default: ;
      endcase
    end
    if (c == nmea_sc_pkg::CH_NEWLINE || eol) begin
      done = 1'b1;
      r.sentence_kind = nmea_sc_pkg::KIND_OTHER;
      r.field_total = 6'd1;
      if (line_st.phase == nmea_sc_pkg::PH_HUNT) begin
        r.line_status = nmea_sc_pkg::ST_NO_DOLLAR;
      end else begin
        if (line_st.phase != nmea_sc_pkg::PH_TAIL || line_st.hex_bad)
          r.line_status = nmea_sc_pkg::ST_MALFORMED;
        else if (line_st.xor_acc != line_st.hex_value)
          r.line_status = nmea_sc_pkg::ST_MISMATCH;
        else
          r.line_status = nmea_sc_pkg::ST_VALID;
        case (line_st.tag_tail)
          nmea_sc_pkg::TAG_RMC: r.sentence_kind = nmea_sc_pkg::KIND_RMC;
          nmea_sc_pkg::TAG_VTG: r.sentence_kind = nmea_sc_pkg::KIND_VTG;
          nmea_sc_pkg::TAG_GGA: r.sentence_kind = nmea_sc_pkg::KIND_GGA;
          default: r.sentence_kind = nmea_sc_pkg::KIND_OTHER;
        endcase
        r.field_total = line_st.comma_total + 6'd1;
        r.computed_sum = line_st.xor_acc;
        r.received_sum = (r.line_status == nmea_sc_pkg::ST_MALFORMED) ?
                         8'h00 : line_st.hex_value;
        if (r.line_status != nmea_sc_pkg::ST_VALID &&
            bad_line_count != nmea_sc_pkg::BAD_MAX) bad_line_count++;
      end
      r.bad_line_total = bad_line_count;
      line_st = nmea_sc_pkg::LINE_CLEAR;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Line builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // any byte that may sit in a body: no star, no newline
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] c;
    if ($urandom_range(15) == 0) return nmea_sc_pkg::CH_DOLLAR;
    do c = 8'($urandom_range(255));
    while (c == nmea_sc_pkg::CH_STAR || c == nmea_sc_pkg::CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = 8'($urandom_range(255));
      d = hex_nibble(c);
    end while (!d[4] || c == nmea_sc_pkg::CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] rand_upper();
    return 8'h41 + 8'($urandom_range(25));
  endfunction

  task automatic start_line();
    line_buf.delete();
    body_xor = 8'h00;
  endtask

  task automatic put_raw(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endtask

  task automatic put_body(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
    body_xor ^= c;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_body(s[i]);
  endtask

  task automatic put_tail(input tail_e t, input bit lower);
    logic [7:0] sum;
    sum = body_xor;
    if (t != TAIL_NONE) put_raw(nmea_sc_pkg::CH_STAR);
    case (t)
      TAIL_GOOD, TAIL_WRONG: begin
        if (t == TAIL_WRONG) sum ^= 8'($urandom_range(1, 255));
        put_raw(hex_char(sum[7:4], lower));
        put_raw(hex_char(sum[3:0], lower));
      end
      TAIL_ONE_DIGIT: put_raw(hex_char(sum[7:4], lower));
      TAIL_BAD_DIGIT: begin
        // bad digit in either position
        if ($urandom_range(1)) begin
          put_raw(rand_non_hex());
          put_raw(hex_char(sum[3:0], lower));
        end else begin
          put_raw(hex_char(sum[7:4], lower));
          put_raw(rand_non_hex());
        end
      end
      default: ;
    endcase
  endtask

  // Moves the built line into the request queue with the chosen ending.
  task automatic flush_line(input line_end_e how);
    text_req_t req;
    if (how == END_FLAG && line_buf.size() == 0) how = END_NL;
    if (how != END_FLAG) line_buf.insert(line_buf.size(), nmea_sc_pkg::CH_NEWLINE);
    foreach (line_buf[i]) begin
      req.ch = line_buf[i];
      req.last = (i == line_buf.size() - 1) && (how != END_NL);
      text_q.insert(text_q.size(), req);
    end
    bytes_queued += line_buf.size();
  endtask

  // Mostly well-formed sentences with random content; some noise and broken tails.
  task automatic queue_random_line();
    int pick, nf;
    bit long_line;
    tail_e tail;
    start_line();
    pick = $urandom_range(99);
    if (pick < 5) begin
      flush_line(END_NL);  // empty line
      return;
    end
    if (pick < 14) begin
      // noise: arbitrary bytes, a '$' among them now and then
      repeat ($urandom_range(1, 12)) put_raw(rand_body_byte() ^ ($urandom_range(3) == 0 ?
                                             8'h00 : 8'h00));
      flush_line(line_end_e'($urandom_range(2)));
      return;
    end
    // junk before the dollar, a star allowed
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(3) == 0) put_raw(nmea_sc_pkg::CH_STAR);
      else put_raw(8'($urandom_range(8'h41, 8'h7A)));
    end
    put_raw(nmea_sc_pkg::CH_DOLLAR);
    case ($urandom_range(5))
      0, 1, 2: begin
        repeat ($urandom_range(0, 1) * 2) put_body(rand_upper());
        case ($urandom_range(2))
          0: put_text("RMC");
          1: put_text("VTG");
          default: put_text("GGA");
        endcase
      end
      3: repeat ($urandom_range(3, 5)) put_body(rand_upper());
      4: repeat ($urandom_range(0, 2)) put_body(rand_upper());  // short first field
      default: repeat ($urandom_range(1, 4)) put_body(rand_body_byte());
    endcase
    long_line = ($urandom_range(19) == 0);
    nf = long_line ? $urandom_range(60, 70) : $urandom_range(0, 8);
    repeat (nf) begin
      put_body(nmea_sc_pkg::CH_COMMA);
      repeat (long_line ? $urandom_range(0, 1) : $urandom_range(0, 4)) put_body(rand_body_byte());
    end
    pick = $urandom_range(99);
    if (pick < 55) tail = TAIL_GOOD;
    else if (pick < 70) tail = TAIL_WRONG;
    else if (pick < 78) tail = TAIL_NONE;
    else if (pick < 84) tail = TAIL_STAR_ONLY;
    else if (pick < 91) tail = TAIL_ONE_DIGIT;
    else tail = TAIL_BAD_DIGIT;
    put_tail(tail, $urandom_range(1));
    // trailing text after the checksum is ignored by the checker
    pick = $urandom_range(9);
    if (pick < 3) begin
      put_raw(8'h0D);
    end else if (pick == 3) begin
      repeat ($urandom_range(1, 3)) put_raw(rand_body_byte() | 8'h20);
    end
    flush_line(line_end_e'($urandom_range(2)));
  endtask

  task automatic wait_idle();
    while (text_q.size() != 0 || in_valid || line_reports_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: byte requests and result-side backpressure, changed on falling edges
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    text_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      // hold the current request until it is taken
      if (!in_valid || in_took) begin
        if (text_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          req = text_q.pop_front();
          in_valid <= 1'b1;
          in_char_in <= req.ch;
          in_end_of_input <= req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sampled on rising edges. Results are checked before the byte taken
  // in the same cycle is predicted, since that byte's result comes later.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    nmea_sc_pkg::result_t got, want, fresh;
    bit closes;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.line_status = out_line_status;
        got.sentence_kind = out_sentence_kind;
        got.field_total = out_field_total;
        got.computed_sum = out_computed_sum;
        got.received_sum = out_received_sum;
        got.bad_line_total = out_bad_line_total;
        if (line_reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          error_count++;
        end else begin
          want = line_reports_q.pop_front();
          check_field("line_status", 16'(want.line_status), 16'(got.line_status));
          check_field("sentence_kind", 16'(want.sentence_kind), 16'(got.sentence_kind));
          check_field("field_total", 16'(want.field_total), 16'(got.field_total));
          check_field("computed_sum", 16'(want.computed_sum), 16'(got.computed_sum));
          check_field("received_sum", 16'(want.received_sum), 16'(got.received_sum));
          check_field("bad_line_total", want.bad_line_total, got.bad_line_total);
        end
      end
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        predict_line_byte(in_char_in, in_end_of_input, closes, fresh);
        if (closes) line_reports_q.insert(line_reports_q.size(), fresh);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int gap_sel[4];
    int stall_sel[4];
    gap_sel = '{0, 55, 0, 31};
    stall_sel = '{0, 0, 55, 31};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed lines
    start_line();  // empty line
    flush_line(END_NL);
    start_line();  // star but no dollar
    put_raw(nmea_sc_pkg::CH_STAR);
    flush_line(END_NL);
    start_line();  // lone dollar closed by the end flag: star missing
    put_raw(nmea_sc_pkg::CH_DOLLAR);
    flush_line(END_FLAG);
    start_line();  // valid RMC, star before the dollar, CR after the sum
    put_raw(nmea_sc_pkg::CH_STAR);
    put_raw(nmea_sc_pkg::CH_DOLLAR);
    put_text("RMC,");
    put_tail(TAIL_GOOD, 1'b0);
    put_raw(8'h0D);
    flush_line(END_FLAG);
    start_line();  // VTG, wrong sum, newline that also carries the end flag
    put_raw(nmea_sc_pkg::CH_DOLLAR);
    put_text("VTG");
    put_tail(TAIL_WRONG, 1'b0);
    flush_line(END_BOTH);
    start_line();  // second dollar in the body, only one digit
    put_raw(nmea_sc_pkg::CH_DOLLAR);
    put_text("GGA,");
    put_body(nmea_sc_pkg::CH_DOLLAR);
    put_tail(TAIL_ONE_DIGIT, 1'b0);
    flush_line(END_FLAG);
    start_line();  // short first field, non-hex digit after the star
    put_raw(nmea_sc_pkg::CH_DOLLAR);
    put_text("G");
    put_raw(nmea_sc_pkg::CH_STAR);
    put_raw("z");
    put_raw("F");
    flush_line(END_FLAG);
    start_line();  // body byte extremes, lower-case sum
    put_raw(nmea_sc_pkg::CH_DOLLAR);
    put_body(8'hFF);
    put_body(8'h00);
    put_tail(TAIL_GOOD, 1'b1);
    flush_line(END_FLAG);
    wait_idle();

    // random text under each idling pattern
    for (int p = 0; p < 4; p++) begin
      gap_pct = gap_sel[p];
      stall_pct = stall_sel[p];
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) queue_random_line();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
